// File: rtl/fpcm_pkg.sv
`default_nettype none
package fpcm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int FMT_W    = 4;
	localparam int BYTES_W  = 4;
	localparam int MANT_W   = 24;
	localparam int KVAL_W   = 31;
	localparam int PROD_W   = MANT_W + KVAL_W;
	localparam int EXP_W    = 10;
	localparam int POS_W    = 6;
	localparam int WIDE_W   = 64;
	localparam int TDATA_OUT_W = 40;

	localparam logic [FMT_W-1:0] FMT_FLOAT32   = 4'd0;
	localparam logic [FMT_W-1:0] FMT_INT16     = 4'd1;
	localparam logic [FMT_W-1:0] FMT_INT24     = 4'd2;
	localparam logic [FMT_W-1:0] FMT_INT32     = 4'd3;
	localparam logic [FMT_W-1:0] FMT_INT24_HI  = 4'd4;
	localparam logic [FMT_W-1:0] FMT_SILENT2   = 4'd5;
	localparam logic [FMT_W-1:0] FMT_SILENT3   = 4'd6;
	localparam logic [FMT_W-1:0] FMT_SILENT4   = 4'd7;
	localparam logic [FMT_W-1:0] FMT_SILENT8   = 4'd8;
	localparam logic [FMT_W-1:0] FMT_RESET     = FMT_INT32;

	// Significand widths of single and double precision.
	localparam logic [POS_W-1:0] SIG_SINGLE = 6'd24;
	localparam logic [POS_W-1:0] SIG_DOUBLE = 6'd53;

	typedef enum logic [3:0] {
		MODE_PASS   = 4'b0001,
		MODE_SILENT = 4'b0010,
		MODE_TRUNC  = 4'b0100,
		MODE_RNE    = 4'b1000
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [BYTES_W-1:0]  nbytes;
		logic [SAMPLE_W-1:0] mask;
		logic                shl8;
		logic [KVAL_W-1:0]   kval;
		logic [POS_W-1:0]    ktop;
	} fmt_ctrl_t;

	function automatic fmt_ctrl_t decode_fmt(input logic [FMT_W-1:0] fmt);
		fmt_ctrl_t c;
		c.mode   = MODE_SILENT;
		c.nbytes = 4'd4;
		c.mask   = 32'hFFFF_FFFF;
		c.shl8   = 1'b0;
		c.kval   = '0;
		c.ktop   = 6'd0;
		case (fmt)
			FMT_FLOAT32: c.mode = MODE_PASS;
			FMT_INT16: begin
				c.mode = MODE_TRUNC; c.nbytes = 4'd2; c.mask = 32'h0000_FFFF;
				c.kval = 31'd32767; c.ktop = 6'd38;
			end
			FMT_INT24: begin
				c.mode = MODE_TRUNC; c.nbytes = 4'd3; c.mask = 32'h00FF_FFFF;
				c.kval = 31'd8388607; c.ktop = 6'd46;
			end
			FMT_INT32: begin
				c.mode = MODE_RNE; c.kval = 31'd2147483647; c.ktop = 6'd54;
			end
			FMT_INT24_HI: begin
				c.mode = MODE_RNE; c.mask = 32'h00FF_FFFF; c.shl8 = 1'b1;
				c.kval = 31'd8388607; c.ktop = 6'd46;
			end
			FMT_SILENT2: c.nbytes = 4'd2;
			FMT_SILENT3: c.nbytes = 4'd3;
			FMT_SILENT4: c.nbytes = 4'd4;
			FMT_SILENT8: c.nbytes = 4'd8;
			default: c.nbytes = 4'd4;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/fpcm_core.sv
`default_nettype none
module fpcm_core (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [fpcm_pkg::SAMPLE_W-1:0]  in_bits,
	input  wire logic                           in_last,
	input  wire logic [fpcm_pkg::FMT_W-1:0]     fmt,
	output logic      [fpcm_pkg::SAMPLE_W-1:0]  out_word,
	output logic      [fpcm_pkg::BYTES_W-1:0]   out_bytes,
	output logic                                out_last
);

	// Stage 1: clamp and unpack.
	fpcm_pkg::fmt_ctrl_t                  ctrl_s1, ctrl_s2, ctrl_s3;
	logic [fpcm_pkg::SAMPLE_W-1:0]        raw_s1, raw_s2, raw_s3;
	logic                                 last_s1, last_s2, last_s3;
	logic                                 sign_s1, sign_s2, sign_s3;
	logic [fpcm_pkg::MANT_W-1:0]          mant_s1;
	logic signed [fpcm_pkg::EXP_W-1:0]    exp_s1, exp_s2;
	logic [fpcm_pkg::PROD_W-1:0]          prod_s2;
	logic [fpcm_pkg::PROD_W-1:0]          q_s3;
	logic [fpcm_pkg::POS_W-1:0]           rsh_s3;

	logic [7:0]                           ef;
	logic [22:0]                          mf;
	logic                                 is_nan, is_big;
	logic [fpcm_pkg::MANT_W-1:0]          mant_d;
	logic signed [fpcm_pkg::EXP_W-1:0]    exp_d;

	always_comb begin
		ef = in_bits[30:23];
		mf = in_bits[22:0];
		is_nan = (ef == 8'hFF) && (mf != 23'd0);
		is_big = (ef > 8'd127) || ((ef == 8'd127) && (mf != 23'd0));
		if (is_big) begin
			mant_d = {1'b1, 23'd0};
			exp_d  = -10'sd23;
		end else if (ef == 8'd0) begin
			mant_d = {1'b0, mf};
			exp_d  = -10'sd149;
		end else begin
			mant_d = {1'b1, mf};
			exp_d  = $signed({2'b00, ef}) - 10'sd150;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= fpcm_pkg::decode_fmt(fmt);
			raw_s1  <= in_bits;
			last_s1 <= in_last;
			sign_s1 <= is_nan ? 1'b0 : in_bits[31];
			mant_s1 <= mant_d;
			exp_s1  <= exp_d;
		end
	end

	// Stage 2: exact product of the significand and the scale.
	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2 <= ctrl_s1;
			raw_s2  <= raw_s1;
			last_s2 <= last_s1;
			sign_s2 <= sign_s1;
			exp_s2  <= exp_s1;
			prod_s2 <= fpcm_pkg::PROD_W'(mant_s1) * fpcm_pkg::PROD_W'(ctrl_s1.kval);
		end
	end

	// Stage 3: round the product to single or double precision.
	logic [fpcm_pkg::POS_W-1:0]        lead, wsig, dcut;
	logic [fpcm_pkg::PROD_W-1:0]       q3, rem3, half3, mask3;
	logic                              up3;
	logic signed [fpcm_pkg::EXP_W-1:0] sh3;
	logic [fpcm_pkg::POS_W-1:0]        rsh_d;

	always_comb begin
		lead  = prod_s2[ctrl_s2.ktop] ? ctrl_s2.ktop : ctrl_s2.ktop - 6'd1;
		wsig  = (ctrl_s2.mode == fpcm_pkg::MODE_RNE) ? fpcm_pkg::SIG_DOUBLE
		                                             : fpcm_pkg::SIG_SINGLE;
		dcut  = ((lead + 6'd1) > wsig) ? (lead + 6'd1 - wsig) : 6'd0;
		q3    = prod_s2 >> dcut;
		mask3 = (fpcm_pkg::PROD_W'(1) << dcut) - fpcm_pkg::PROD_W'(1);
		rem3  = prod_s2 & mask3;
		half3 = (dcut == 6'd0) ? '0 : (fpcm_pkg::PROD_W'(1) << (dcut - 6'd1));
		up3   = (dcut != 6'd0) && ((rem3 > half3) || ((rem3 == half3) && q3[0]));
		sh3   = -(exp_s2 + $signed({4'b0000, dcut}));
		if (sh3 < 0)
			rsh_d = 6'd0;
		else if (sh3 > 10'sd63)
			rsh_d = 6'd63;
		else
			rsh_d = sh3[fpcm_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s3 <= ctrl_s2;
			raw_s3  <= raw_s2;
			last_s3 <= last_s2;
			sign_s3 <= sign_s2;
			q_s3    <= q3 + fpcm_pkg::PROD_W'(up3);
			rsh_s3  <= rsh_d;
		end
	end

	// Stage 4: scale to an integer, apply sign and pack.
	logic [fpcm_pkg::WIDE_W-1:0]   qx, ip, frac, half4;
	logic                          up4;
	logic [fpcm_pkg::SAMPLE_W-1:0] mag, sgn, word_d;

	always_comb begin
		qx    = fpcm_pkg::WIDE_W'(q_s3);
		ip    = qx >> rsh_s3;
		frac  = qx & ((fpcm_pkg::WIDE_W'(1) << rsh_s3) - fpcm_pkg::WIDE_W'(1));
		half4 = (rsh_s3 == 6'd0) ? '0 : (fpcm_pkg::WIDE_W'(1) << (rsh_s3 - 6'd1));
		up4   = (ctrl_s3.mode == fpcm_pkg::MODE_RNE) && (rsh_s3 != 6'd0) &&
		        ((frac > half4) || ((frac == half4) && ip[0]));
		mag   = ip[fpcm_pkg::SAMPLE_W-1:0] + fpcm_pkg::SAMPLE_W'(up4);
		sgn   = (sign_s3 ? (~mag + 32'd1) : mag) & ctrl_s3.mask;
		case (ctrl_s3.mode)
			fpcm_pkg::MODE_PASS:  word_d = raw_s3;
			fpcm_pkg::MODE_TRUNC: word_d = sgn;
			fpcm_pkg::MODE_RNE:   word_d = ctrl_s3.shl8 ? {sgn[23:0], 8'd0} : sgn;
			default:              word_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word  <= word_d;
			out_bytes <= ctrl_s3.nbytes;
			out_last  <= last_s3;
		end
	end

endmodule
`default_nettype wire

// File: rtl/float_to_pcm_sample_converter.sv
// Converts one single-precision audio sample per beat into float32 pass-through, int16,
// packed int24, int32, int24 in the high bits of 32, or silence, as chosen by the format
// register (reset value: int32). The datapath is four register stages deep (unpack, multiply,
// round to working precision, scale to integer), and a new sample is taken every cycle; when
// the output is stalled the whole pipeline holds. The format is sampled with each beat, and
// should be written only while the block is empty.
`default_nettype none
module float_to_pcm_sample_converter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [fpcm_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [31:0] sample_bits
	input  wire logic                                s_axis_tlast,  // last_in_block
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic      [fpcm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // [31:0] out_word, [35:32] out_bytes
	output logic                                     m_axis_tlast,  // block_end
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [fpcm_pkg::FMT_W-1:0]          cfg_data
);

	logic [fpcm_pkg::FMT_W-1:0]     fmt_q;
	logic                           valid_s1, valid_s2, valid_s3, valid_s4;
	logic                           en;
	logic [fpcm_pkg::SAMPLE_W-1:0]  word;
	logic [fpcm_pkg::BYTES_W-1:0]   nbytes;

	assign en            = !valid_s4 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= fpcm_pkg::FMT_RESET;
		end else if (cfg_valid) begin
			fmt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	fpcm_core u_core (
		.clk      (clk),
		.en       (en),
		.in_bits  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.fmt      (fmt_q),
		.out_word (word),
		.out_bytes(nbytes),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {4'd0, nbytes, word};

endmodule
`default_nettype wire

// File: rtl/fpcm_checker.sv
`default_nettype none
module fpcm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);

	// A stalled result beat holds its data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// The input side is held back only by a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[35:32] == 4'd2 || m_axis_tdata[35:32] == 4'd3 ||
		                   m_axis_tdata[35:32] == 4'd4 || m_axis_tdata[35:32] == 4'd8))
		else $error("byte count out of range");

	// Bytes beyond a two-byte sample's width are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[35:32] == 4'd2 |-> m_axis_tdata[31:16] == 16'd0)
		else $error("two-byte sample has high bits set");

endmodule

bind float_to_pcm_sample_converter fpcm_checker u_fpcm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
